// ===== design/stwc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stwc_pkg: shared types and constants of the split text console
// Word layouts, command codes, state codes and fixed display geometry.
// ----------------------------------------------------------------------------
package stwc_pkg;

   // fixed display and field geometry
   localparam int TEXT_DEPTH  = 1920;
   localparam int TEXT_ADDR_W = 11;
   localparam int DISP_COLS   = 80;
   localparam int CHAR_W      = 8;
   localparam int ATTR_W      = 4;
   localparam int COL_W       = 6;
   localparam int ROW_W       = 4;
   localparam int WIN_W       = 2;
   localparam int IDX_W       = 11;
   localparam int NUM_WIN     = 4;
   localparam int DROW_W      = 5;
   localparam int DCOL_W      = 7;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // divide by 80: q = (idx * 1639) >> 17, exact for idx below 2730
   localparam int ROW_RECIP   = 1639;
   localparam int ROW_SHIFT   = 17;
   localparam int ROW_PROD_W  = 22;

   // attribute: ((idx + 13) mod 15) + 1, quotient by (v * 2185) >> 15
   localparam int ATTR_OFFSET = 13;
   localparam int ATTR_MOD    = 15;
   localparam int ATTR_RECIP  = 2185;
   localparam int ATTR_SHIFT  = 15;
   localparam int ATTR_VAL_W  = 12;
   localparam int ATTR_PROD_W = 24;
   localparam int ATTR_Q_W    = 8;

   // control characters
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_RETURN    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;

   typedef enum logic [2:0] {
      CMD_WRITE,
      CMD_NEWLINE,
      CMD_RETURN,
      CMD_BACKSPACE,
      CMD_READ
   } cmd_kind_type;

   // one classified word as it travels through the command queue
   typedef struct packed {
      cmd_kind_type              kind;
      logic [WIN_W-1:0]          window;
      logic [CHAR_W-1:0]         char_code;
      logic                      hit;
      logic [TEXT_ADDR_W-1:0]    addr;
      logic [ATTR_W-1:0]         attr;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SCROLL,
      ST_DRAIN
   } back_state_type;

endpackage
`default_nettype wire

// ===== design/split_text_console_windows.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// split_text_console_windows: four tiled text windows on an 80-column screen
// Put words write characters and control codes into a window; read words
// return a screen cell's character and attribute plus the window's cursor.
//
//   channel   ports                                   handshake
//   request   req_op req_window req_char_code         req_push / req_full
//             req_cell_index
//   response  rsp_cell_char rsp_cell_attr             rsp_pop / rsp_empty
//             rsp_cursor_col rsp_cursor_row
//
// A read, unlike a put, also passes ST_READ (registered store read port).
// A put that scrolls then passes through ST_SCROLL and ST_DRAIN, one store cell per
// cycle through the single read and single write port.
// After reset a clearing pass writes spaces over all 1920 cells; req_full
// stays high while it runs.
// A two-word command queue lets requests enter while the engine works, and
// the output register holds a word until it is popped, stalling the engine.
// ----------------------------------------------------------------------------
module split_text_console_windows #(
   parameter int WIN_COLS = 40,
   parameter int WIN_ROWS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic                                 req_op,
   input  logic [stwc_pkg::WIN_W-1:0]           req_window,
   input  logic [stwc_pkg::CHAR_W-1:0]          req_char_code,
   input  logic [stwc_pkg::IDX_W-1:0]           req_cell_index,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic [stwc_pkg::CHAR_W-1:0]          rsp_cell_char,
   output logic [stwc_pkg::ATTR_W-1:0]          rsp_cell_attr,
   output logic [stwc_pkg::COL_W-1:0]           rsp_cursor_col,
   output logic [stwc_pkg::ROW_W-1:0]           rsp_cursor_row
);
   import stwc_pkg::*;

   queue_status_type q_status;
   cmd_type          q_cmd;
   cmd_type          head_cmd;
   logic             q_push;
   logic             q_pop;
   logic             clearing;

   // request decode
   stwc_front #(
      .WIN_COLS (WIN_COLS),
      .WIN_ROWS (WIN_ROWS)
   ) u_front (
      .req_push       (req_push),
      .req_full       (req_full),
      .req_op         (req_op),
      .req_window     (req_window),
      .req_char_code  (req_char_code),
      .req_cell_index (req_cell_index),
      .clearing       (clearing),
      .q_status       (q_status),
      .q_push         (q_push),
      .q_cmd          (q_cmd)
   );

   // command queue
   stwc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   // console engine
   stwc_back #(
      .WIN_COLS (WIN_COLS),
      .WIN_ROWS (WIN_ROWS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .head_cmd       (head_cmd),
      .q_pop          (q_pop),
      .clearing       (clearing),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_cell_char  (rsp_cell_char),
      .rsp_cell_attr  (rsp_cell_attr),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row)
   );

endmodule
`default_nettype wire

// ===== design/stwc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stwc_front: request decode
// Accepts request words, sorts puts by character class and turns read
// cell numbers into window store addresses and attributes.
// ----------------------------------------------------------------------------
module stwc_front #(
   parameter int WIN_COLS = 40,
   parameter int WIN_ROWS = 12
) (
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic                                 req_op,
   input  logic [stwc_pkg::WIN_W-1:0]           req_window,
   input  logic [stwc_pkg::CHAR_W-1:0]          req_char_code,
   input  logic [stwc_pkg::IDX_W-1:0]           req_cell_index,
   input  logic                                 clearing,
   input  stwc_pkg::queue_status_type           q_status,
   output logic                                 q_push,
   output stwc_pkg::cmd_type                    q_cmd
);
   import stwc_pkg::*;

   localparam int AREA = WIN_COLS * WIN_ROWS;

   logic [ROW_PROD_W-1:0]  row_prod;
   logic [DROW_W-1:0]      disp_row;
   logic [IDX_W-1:0]       col_full;
   logic [DCOL_W-1:0]      disp_col;
   logic [ATTR_VAL_W-1:0]  attr_val;
   logic [ATTR_PROD_W-1:0] attr_prod;
   logic [ATTR_Q_W-1:0]    attr_q;
   logic [ATTR_VAL_W-1:0]  attr_rem;
   logic                   hit;
   logic                   win_r;
   logic                   win_c;
   logic [DROW_W-1:0]      wrow;
   logic [DCOL_W-1:0]      wcol;

   // handshake
   assign req_full = q_status.full | clearing;
   assign q_push   = req_push & ~req_full;

   // display row and column by reciprocal multiply
   assign row_prod = ROW_PROD_W'(req_cell_index) * ROW_PROD_W'(ROW_RECIP);
   assign disp_row = row_prod[ROW_SHIFT +: DROW_W];
   assign col_full = req_cell_index - IDX_W'(disp_row) * IDX_W'(DISP_COLS);
   assign disp_col = col_full[DCOL_W-1:0];

   // cycling attribute
   assign attr_val  = ATTR_VAL_W'(req_cell_index) + ATTR_VAL_W'(ATTR_OFFSET);
   assign attr_prod = ATTR_PROD_W'(attr_val) * ATTR_PROD_W'(ATTR_RECIP);
   assign attr_q    = attr_prod[ATTR_SHIFT +: ATTR_Q_W];
   assign attr_rem  = attr_val - ATTR_VAL_W'(attr_q) * ATTR_VAL_W'(ATTR_MOD);

   // which window covers the cell
   always_comb begin
      hit   = 1'b1;
      win_r = 1'b0;
      win_c = 1'b0;
      wrow  = disp_row;
      wcol  = disp_col;
      if (disp_row < DROW_W'(WIN_ROWS)) begin
         win_r = 1'b0;
      end else if (disp_row < DROW_W'(2 * WIN_ROWS)) begin
         win_r = 1'b1;
         wrow  = disp_row - DROW_W'(WIN_ROWS);
      end else begin
         hit = 1'b0;
      end
      if (disp_col < DCOL_W'(WIN_COLS)) begin
         win_c = 1'b0;
      end else if (disp_col < DCOL_W'(2 * WIN_COLS)) begin
         win_c = 1'b1;
         wcol  = disp_col - DCOL_W'(WIN_COLS);
      end else begin
         hit = 1'b0;
      end
   end

   // classified command word
   always_comb begin
      q_cmd.window    = req_window;
      q_cmd.char_code = req_char_code;
      q_cmd.hit       = hit;
      q_cmd.attr      = attr_rem[ATTR_W-1:0] + ATTR_W'(1);
      if (hit) begin
         q_cmd.addr = TEXT_ADDR_W'(int'({win_r, win_c}) * AREA + int'(wrow) * WIN_COLS
                                   + int'(wcol));
      end else begin
         q_cmd.addr = '0;
      end
      if (req_op) begin
         q_cmd.kind = CMD_READ;
      end else begin
         unique case (req_char_code)
            CHAR_NEWLINE:   q_cmd.kind = CMD_NEWLINE;
            CHAR_RETURN:    q_cmd.kind = CMD_RETURN;
            CHAR_BACKSPACE: q_cmd.kind = CMD_BACKSPACE;
            default:        q_cmd.kind = CMD_WRITE;
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== design/stwc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stwc_queue: command queue
// Short first-in first-out buffer of classified words between front and back.
// ----------------------------------------------------------------------------
module stwc_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  stwc_pkg::cmd_type           push_cmd,
   input  logic                        pop,
   output stwc_pkg::cmd_type           head_cmd,
   output stwc_pkg::queue_status_type  status
);
   import stwc_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign head_cmd     = entries_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

// ===== design/stwc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stwc_back: console engine
// Holds the window text store and cursors, carries out puts, reads and
// scrolls, and presents finished words in an output register.
// ----------------------------------------------------------------------------
module stwc_back #(
   parameter int WIN_COLS = 40,
   parameter int WIN_ROWS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  stwc_pkg::queue_status_type           q_status,
   input  stwc_pkg::cmd_type                    head_cmd,
   output logic                                 q_pop,
   output logic                                 clearing,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic [stwc_pkg::CHAR_W-1:0]          rsp_cell_char,
   output logic [stwc_pkg::ATTR_W-1:0]          rsp_cell_attr,
   output logic [stwc_pkg::COL_W-1:0]           rsp_cursor_col,
   output logic [stwc_pkg::ROW_W-1:0]           rsp_cursor_row
);
   import stwc_pkg::*;

   localparam int AREA   = WIN_COLS * WIN_ROWS;
   localparam int COPY_N = AREA - WIN_COLS;

   back_state_type         state_ff, state_in;
   logic [TEXT_ADDR_W-1:0] cnt_ff, cnt_in;
   cmd_type                cmd_ff, cmd_in;
   logic [COL_W-1:0]       cursor_col_ff [NUM_WIN];
   logic [COL_W-1:0]       cursor_col_in [NUM_WIN];
   logic [ROW_W-1:0]       cursor_row_ff [NUM_WIN];
   logic [ROW_W-1:0]       cursor_row_in [NUM_WIN];
   logic                   wr_valid_ff, wr_valid_in;
   logic [TEXT_ADDR_W-1:0] wr_off_ff, wr_off_in;
   logic                   out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]      out_char_ff, out_char_in;
   logic [ATTR_W-1:0]      out_attr_ff, out_attr_in;
   logic [COL_W-1:0]       out_col_ff, out_col_in;
   logic [ROW_W-1:0]       out_row_ff, out_row_in;

   logic [CHAR_W-1:0]      text_mem [TEXT_DEPTH];
   logic [CHAR_W-1:0]      rd_data_ff;
   logic                   mem_we;
   logic [TEXT_ADDR_W-1:0] mem_wa;
   logic [CHAR_W-1:0]      mem_wd;
   logic [TEXT_ADDR_W-1:0] rd_addr;

   logic                   slot_free;
   logic [TEXT_ADDR_W-1:0] scr_base;
   logic [TEXT_ADDR_W-1:0] cursor_addr;
   logic [WIN_W-1:0]       w;
   logic [COL_W-1:0]       cur_col, new_col;
   logic [ROW_W-1:0]       cur_row, new_row;
   logic                   need_next_row;
   logic                   need_scroll;

   assign clearing       = (state_ff == ST_CLEAR);
   assign rsp_empty      = ~out_valid_ff;
   assign rsp_cell_char  = out_char_ff;
   assign rsp_cell_attr  = out_attr_ff;
   assign rsp_cursor_col = out_col_ff;
   assign rsp_cursor_row = out_row_ff;
   assign slot_free      = ~out_valid_ff | rsp_pop;

   // addresses of the window being scrolled and of the head word's cursor
   assign w           = head_cmd.window;
   assign cur_col     = cursor_col_ff[w];
   assign cur_row     = cursor_row_ff[w];
   assign scr_base    = TEXT_ADDR_W'(int'(cmd_ff.window) * AREA);
   assign cursor_addr = TEXT_ADDR_W'(int'(w) * AREA + int'(cur_row) * WIN_COLS + int'(cur_col));

   // next state, store access and result word
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cmd_in        = cmd_ff;
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      wr_valid_in   = 1'b0;
      wr_off_in     = cnt_ff;
      out_valid_in  = out_valid_ff & ~rsp_pop;
      out_char_in   = out_char_ff;
      out_attr_in   = out_attr_ff;
      out_col_in    = out_col_ff;
      out_row_in    = out_row_ff;
      mem_we        = 1'b0;
      mem_wa        = '0;
      mem_wd        = CHAR_SPACE;
      rd_addr       = head_cmd.addr;
      q_pop         = 1'b0;
      new_col       = cur_col;
      new_row       = cur_row;
      need_next_row = 1'b0;
      need_scroll   = 1'b0;

      // delayed write of the scroll copy, one cell behind its read
      if (wr_valid_ff) begin
         mem_we = 1'b1;
         mem_wa = scr_base + wr_off_ff;
         mem_wd = (wr_off_ff < TEXT_ADDR_W'(COPY_N)) ? rd_data_ff : CHAR_SPACE;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = cnt_ff;
            mem_wd = CHAR_SPACE;
            if (cnt_ff == TEXT_ADDR_W'(TEXT_DEPTH - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + TEXT_ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            if (!q_status.empty && slot_free) begin
               q_pop  = 1'b1;
               cmd_in = head_cmd;
               unique case (head_cmd.kind)
                  CMD_WRITE: begin
                     mem_we = 1'b1;
                     mem_wa = cursor_addr;
                     mem_wd = head_cmd.char_code;
                     if (cur_col >= COL_W'(WIN_COLS - 1)) begin
                        new_col       = '0;
                        need_next_row = 1'b1;
                     end else begin
                        new_col = cur_col + COL_W'(1);
                     end
                  end
                  CMD_NEWLINE: begin
                     need_next_row = 1'b1;
                  end
                  CMD_RETURN: begin
                     new_col = '0;
                  end
                  CMD_BACKSPACE: begin
                     if (cur_col == '0 && cur_row != '0) begin
                        new_col = COL_W'(WIN_COLS - 1);
                        new_row = cur_row - ROW_W'(1);
                     end else if (cur_col != '0) begin
                        new_col = cur_col - COL_W'(1);
                     end
                  end
                  CMD_READ: begin
                  end
                  default: begin
                  end
               endcase
               // move down a row, scrolling at the bottom
               if (need_next_row) begin
                  if (cur_row >= ROW_W'(WIN_ROWS - 1)) begin
                     need_scroll = 1'b1;
                     new_row     = ROW_W'(WIN_ROWS - 1);
                  end else begin
                     new_row = cur_row + ROW_W'(1);
                  end
               end
               cursor_col_in[w] = new_col;
               cursor_row_in[w] = new_row;
               if (head_cmd.kind == CMD_READ) begin
                  state_in = ST_READ;
               end else begin
                  out_valid_in = 1'b1;
                  out_char_in  = '0;
                  out_attr_in  = '0;
                  out_col_in   = new_col;
                  out_row_in   = new_row;
                  if (need_scroll) begin
                     cnt_in   = '0;
                     state_in = ST_SCROLL;
                  end
               end
            end
         end
         ST_READ: begin
            out_valid_in = 1'b1;
            out_char_in  = cmd_ff.hit ? rd_data_ff : CHAR_SPACE;
            out_attr_in  = cmd_ff.attr;
            out_col_in   = cursor_col_ff[cmd_ff.window];
            out_row_in   = cursor_row_ff[cmd_ff.window];
            state_in     = ST_IDLE;
         end
         ST_SCROLL: begin
            if (cnt_ff < TEXT_ADDR_W'(COPY_N)) begin
               rd_addr = scr_base + cnt_ff + TEXT_ADDR_W'(WIN_COLS);
            end else begin
               rd_addr = scr_base;
            end
            wr_valid_in = 1'b1;
            wr_off_in   = cnt_ff;
            if (cnt_ff == TEXT_ADDR_W'(AREA - 1)) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + TEXT_ADDR_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         cnt_ff        <= '0;
         wr_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         cursor_col_ff <= '{default: '0};
         cursor_row_ff <= '{default: '0};
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         wr_valid_ff   <= wr_valid_in;
         out_valid_ff  <= out_valid_in;
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      wr_off_ff   <= wr_off_in;
      out_char_ff <= out_char_in;
      out_attr_ff <= out_attr_in;
      out_col_ff  <= out_col_in;
      out_row_ff  <= out_row_in;
   end

   // window text store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         text_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= text_mem[rd_addr];
   end

endmodule
`default_nettype wire
